// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the bounding box unit.
// Both macros expect a signal named clk in the using scope; SWB_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define SWB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SWB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/swb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the bounding box unit.
// No dependencies.
package swb_pkg;

  localparam int COMPONENT_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF   = 14;
  localparam int FRAC_BITS          = 8;
  localparam int TRIG_FRAC          = 14;
  localparam int CORDIC_FRAC        = 24;
  localparam int CORDIC_GAIN        = 10188014;
  localparam int ATAN_LEN           = 20;
  // Width of sines, cosines and two-factor rotation products.
  localparam int TRIG_W             = 18;
  // Width of one absolute rotation matrix term.
  localparam int MAT_W              = 19;

  typedef enum logic [1:0] {
    KIND_BOX      = 2'd0,
    KIND_SPHERE   = 2'd1,
    KIND_CAPSULE  = 2'd2,
    KIND_ORIENTED = 2'd3
  } shape_kind_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Q1.14 product, truncated toward minus infinity.
  function automatic logic signed [TRIG_W-1:0] tmul(input logic signed [TRIG_W-1:0] a,
                                                    input logic signed [TRIG_W-1:0] b);
    logic signed [2*TRIG_W-1:0] p;
    p = a * b;
    return p[TRIG_FRAC +: TRIG_W];
  endfunction

endpackage

// ===== rtl/swb_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for shape items and box results.
// Depends on swb_pkg.
interface swb_in_if import swb_pkg::*; #(parameter int CB = COMPONENT_BITS_DEF) ();
  logic              valid;
  logic              ready;
  logic [1:0]        shape_kind;
  logic [3*CB-1:0]   position_xyz;
  logic [3*CB-1:0]   shape_offset_xyz;
  logic [3*CB-1:0]   scale_xyz;
  logic [3*CB-1:0]   half_size_xyz;
  logic [15:0]       radius;
  logic [15:0]       height;
  logic [47:0]       angles_xyz;

  modport source (output valid, shape_kind, position_xyz, shape_offset_xyz, scale_xyz,
                  half_size_xyz, radius, height, angles_xyz, input ready);
  modport sink   (input valid, shape_kind, position_xyz, shape_offset_xyz, scale_xyz,
                  half_size_xyz, radius, height, angles_xyz, output ready);
endinterface

interface swb_out_if import swb_pkg::*; #(parameter int CB = COMPONENT_BITS_DEF) ();
  logic              valid;
  logic              ready;
  logic [3*CB-1:0]   min_corner_xyz;
  logic [3*CB-1:0]   max_corner_xyz;
  logic              clipped;

  modport source (output valid, min_corner_xyz, max_corner_xyz, clipped, input ready);
  modport sink   (input valid, min_corner_xyz, max_corner_xyz, clipped, output ready);
endinterface

// ===== rtl/shape_world_bounding_box_unit.sv =====
`timescale 1ns / 1ps
// Top level of the world bounding box unit: input decode, CORDIC lanes, rotation
// and extent stages, saturation. Depends on swb_pkg, swb_if, swb_cordic.
//
// Usage: shape items enter on in_bus, one transfer per cycle at most, and each
// gives exactly one box result on out_bus, in order. Components are signed
// fixed point with 8 fraction bits, packed x in the low bits.
// Every shape kind takes the same path from input transfer to output valid.
// Throughput is one item per cycle while the receiver does not stall: the
// whole datapath is one pipeline whose depth is set by the unrolled CORDIC
// stages, three in parallel, one per Euler angle.
// When the receiver stalls, the complete pipeline holds in place; in_bus.ready
// falls only while a result waits in the output register and out_bus.ready is
// low, so nothing is dropped or repeated.
// Reset clears all valid bits; data registers are not reset. No configuration.
`include "assert_macros.svh"

module shape_world_bounding_box_unit import swb_pkg::*; #(
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
  parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  swb_in_if.sink    in_bus,
  swb_out_if.source out_bus
);

  localparam int CB  = COMPONENT_BITS;
  localparam int LC  = CORDIC_STEPS + 2;
  localparam int NST = LC + 5;
  localparam int HW  = 2 * CB - 7;
  localparam int EW  = 2 * CB + 2;
  localparam int RW  = CB + 8;
  localparam logic signed [EW:0] MAXV = (EW+1)'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [EW:0] MINV = -MAXV - (EW+1)'(1);

  logic adv;
  logic [NST-1:0] vld_r;

  // The whole pipeline moves whenever the output slot is free or drained.
  assign adv          = !out_bus.valid || out_bus.ready;
  assign in_bus.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_bus.valid};
    end
  end

  // Stage 1: unpack, center sum and absolute scale.
  shape_kind_t        s1_kind_r;
  logic signed [CB:0] s1_ctr_r  [3];
  logic [CB-1:0]      s1_sc_r   [3];
  logic signed [CB-1:0] s1_half_r [3];
  logic [15:0]        s1_rad_r;
  logic [15:0]        s1_hgt_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r <= shape_kind_t'(in_bus.shape_kind);
      s1_rad_r  <= in_bus.radius;
      s1_hgt_r  <= in_bus.height;
      for (int k = 0; k < 3; k++) begin
        s1_ctr_r[k]  <= (CB+1)'($signed(in_bus.position_xyz[k*CB +: CB]))
                      + (CB+1)'($signed(in_bus.shape_offset_xyz[k*CB +: CB]));
        s1_sc_r[k]   <= in_bus.scale_xyz[k*CB + CB - 1]
                      ? CB'(-$signed(in_bus.scale_xyz[k*CB +: CB]))
                      : in_bus.scale_xyz[k*CB +: CB];
        s1_half_r[k] <= $signed(in_bus.half_size_xyz[k*CB +: CB]);
      end
    end
  end

  // Stage 2: scaled half extents and the extents of the unrotated kinds.
  logic [CB-1:0]        ms;
  logic [RW-1:0]        rr;
  logic [RW-1:0]        hh;
  logic signed [HW-1:0] he_nxt  [3];
  logic signed [EW-1:0] exs_nxt [3];
  logic signed [2*CB:0] hprod   [3];
  logic [RW+7:0]        rprod;
  logic [RW+7:0]        hprod_y;

  always_comb begin
    ms = s1_sc_r[0];
    if (s1_sc_r[1] > ms) ms = s1_sc_r[1];
    if (s1_sc_r[2] > ms) ms = s1_sc_r[2];
    rprod   = s1_rad_r * ms;
    hprod_y = s1_hgt_r * s1_sc_r[1];
    rr = rprod[FRAC_BITS +: RW];
    hh = hprod_y[FRAC_BITS +: RW];
    for (int k = 0; k < 3; k++) begin
      hprod[k]  = s1_half_r[k] * $signed({1'b0, s1_sc_r[k]});
      he_nxt[k] = hprod[k][FRAC_BITS +: HW];
    end
    case (s1_kind_r)
      KIND_SPHERE: begin
        for (int k = 0; k < 3; k++) exs_nxt[k] = EW'(rr);
      end
      KIND_CAPSULE: begin
        exs_nxt[0] = EW'(rr);
        exs_nxt[1] = EW'(hh >> 1) + EW'(rr);
        exs_nxt[2] = EW'(rr);
      end
      default: begin
        for (int k = 0; k < 3; k++) exs_nxt[k] = EW'(he_nxt[k]);
      end
    endcase
  end

  // Delay line that holds the side data level with the CORDIC lanes.
  shape_kind_t          dly_kind_r [LC-1];
  logic signed [CB:0]   dly_ctr_r  [LC-1][3];
  logic signed [HW-1:0] dly_he_r   [LC-1][3];
  logic signed [EW-1:0] dly_exs_r  [LC-1][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_kind_r[0] <= s1_kind_r;
      for (int k = 0; k < 3; k++) begin
        dly_ctr_r[0][k] <= s1_ctr_r[k];
        dly_he_r[0][k]  <= he_nxt[k];
        dly_exs_r[0][k] <= exs_nxt[k];
      end
      for (int d = 1; d < LC - 1; d++) begin
        dly_kind_r[d] <= dly_kind_r[d-1];
        dly_ctr_r[d]  <= dly_ctr_r[d-1];
        dly_he_r[d]   <= dly_he_r[d-1];
        dly_exs_r[d]  <= dly_exs_r[d-1];
      end
    end
  end

  // Sine and cosine lanes, one per Euler angle.
  logic signed [TRIG_W-1:0] sn [3];
  logic signed [TRIG_W-1:0] cs [3];

  for (genvar a = 0; a < 3; a++) begin : g_lane
    swb_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clk  (clk),
      .en   (adv),
      .ang  (in_bus.angles_xyz[a*16 +: 16]),
      .sin_o(sn[a]),
      .cos_o(cs[a])
    );
  end

  // Stage T1: two-factor rotation products.
  shape_kind_t              t1_kind_r;
  logic signed [CB:0]       t1_ctr_r [3];
  logic signed [HW-1:0]     t1_he_r  [3];
  logic signed [EW-1:0]     t1_exs_r [3];
  logic signed [TRIG_W-1:0] t1_sy_r, t1_cz_r, t1_sz_r;
  logic signed [TRIG_W-1:0] t1_cycz_r, t1_cysz_r, t1_sxsy_r, t1_cxsz_r, t1_cxcz_r;
  logic signed [TRIG_W-1:0] t1_sxcy_r, t1_cxsy_r, t1_sxsz_r, t1_sxcz_r, t1_cxcy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_kind_r <= dly_kind_r[LC-2];
      t1_ctr_r  <= dly_ctr_r[LC-2];
      t1_he_r   <= dly_he_r[LC-2];
      t1_exs_r  <= dly_exs_r[LC-2];
      t1_sy_r   <= sn[1];
      t1_cz_r   <= cs[2];
      t1_sz_r   <= sn[2];
      t1_cycz_r <= tmul(cs[1], cs[2]);
      t1_cysz_r <= tmul(cs[1], sn[2]);
      t1_sxsy_r <= tmul(sn[0], sn[1]);
      t1_cxsz_r <= tmul(cs[0], sn[2]);
      t1_cxcz_r <= tmul(cs[0], cs[2]);
      t1_sxcy_r <= tmul(sn[0], cs[1]);
      t1_cxsy_r <= tmul(cs[0], sn[1]);
      t1_sxsz_r <= tmul(sn[0], sn[2]);
      t1_sxcz_r <= tmul(sn[0], cs[2]);
      t1_cxcy_r <= tmul(cs[0], cs[1]);
    end
  end

  // Stage T2: triple products, matrix terms and their magnitudes.
  logic signed [MAT_W-1:0] m_nxt [3][3];
  logic [MAT_W-1:0]        t2_m_r [3][3];
  shape_kind_t             t2_kind_r;
  logic signed [CB:0]      t2_ctr_r [3];
  logic signed [HW-1:0]    t2_he_r  [3];
  logic signed [EW-1:0]    t2_exs_r [3];

  always_comb begin
    m_nxt[0][0] = MAT_W'(t1_cycz_r);
    m_nxt[0][1] = -MAT_W'(t1_cysz_r);
    m_nxt[0][2] = MAT_W'(t1_sy_r);
    m_nxt[1][0] = MAT_W'(tmul(t1_sxsy_r, t1_cz_r)) + MAT_W'(t1_cxsz_r);
    m_nxt[1][1] = -MAT_W'(tmul(t1_sxsy_r, t1_sz_r)) + MAT_W'(t1_cxcz_r);
    m_nxt[1][2] = -MAT_W'(t1_sxcy_r);
    m_nxt[2][0] = -MAT_W'(tmul(t1_cxsy_r, t1_cz_r)) + MAT_W'(t1_sxsz_r);
    m_nxt[2][1] = MAT_W'(tmul(t1_cxsy_r, t1_sz_r)) + MAT_W'(t1_sxcz_r);
    m_nxt[2][2] = MAT_W'(t1_cxcy_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t2_kind_r <= t1_kind_r;
      t2_ctr_r  <= t1_ctr_r;
      t2_he_r   <= t1_he_r;
      t2_exs_r  <= t1_exs_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          t2_m_r[i][j] <= m_nxt[i][j][MAT_W-1] ? MAT_W'(-m_nxt[i][j]) : MAT_W'(m_nxt[i][j]);
        end
      end
    end
  end

  // Stage T3: matrix magnitude times scaled half extent.
  logic signed [HW+MAT_W:0] qprod [3][3];
  logic signed [EW-1:0]     t3_q_r [3][3];
  shape_kind_t              t3_kind_r;
  logic signed [CB:0]       t3_ctr_r [3];
  logic signed [EW-1:0]     t3_exs_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        qprod[i][j] = $signed({1'b0, t2_m_r[i][j]}) * t2_he_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t3_kind_r <= t2_kind_r;
      t3_ctr_r  <= t2_ctr_r;
      t3_exs_r  <= t2_exs_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          t3_q_r[i][j] <= EW'(qprod[i][j] >>> TRIG_FRAC);
        end
      end
    end
  end

  // Stage T4: row sums and extent selection by kind.
  logic signed [EW-1:0] ext_nxt [3];
  logic signed [EW-1:0] t4_ext_r [3];
  logic signed [CB:0]   t4_ctr_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (t3_kind_r == KIND_ORIENTED) begin
        ext_nxt[k] = t3_q_r[k][0] + t3_q_r[k][1] + t3_q_r[k][2];
      end else begin
        ext_nxt[k] = t3_exs_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t4_ext_r <= ext_nxt;
      t4_ctr_r <= t3_ctr_r;
    end
  end

  // Stage T5: corners, saturation and the output register.
  logic signed [EW:0]   lo_w [3];
  logic signed [EW:0]   hi_w [3];
  logic [3*CB-1:0]      mn_nxt, mx_nxt;
  logic                 clip_nxt;
  logic [3*CB-1:0]      mn_r, mx_r;
  logic                 clip_r;

  always_comb begin
    clip_nxt = 1'b0;
    mn_nxt   = '0;
    mx_nxt   = '0;
    for (int k = 0; k < 3; k++) begin
      lo_w[k] = (EW+1)'(t4_ctr_r[k]) - (EW+1)'(t4_ext_r[k]);
      hi_w[k] = (EW+1)'(t4_ctr_r[k]) + (EW+1)'(t4_ext_r[k]);
      if (lo_w[k] > MAXV) begin
        lo_w[k] = MAXV;
        clip_nxt = 1'b1;
      end else if (lo_w[k] < MINV) begin
        lo_w[k] = MINV;
        clip_nxt = 1'b1;
      end
      if (hi_w[k] > MAXV) begin
        hi_w[k] = MAXV;
        clip_nxt = 1'b1;
      end else if (hi_w[k] < MINV) begin
        hi_w[k] = MINV;
        clip_nxt = 1'b1;
      end
      mn_nxt[k*CB +: CB] = lo_w[k][CB-1:0];
      mx_nxt[k*CB +: CB] = hi_w[k][CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mn_r   <= mn_nxt;
      mx_r   <= mx_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_bus.valid          = vld_r[NST-1];
  assign out_bus.min_corner_xyz = mn_r;
  assign out_bus.max_corner_xyz = mx_r;
  assign out_bus.clipped        = clip_r;

  // A stall freezes every valid bit of the pipeline.
  `SWB_ASSERT(a_stall_holds, !adv |=> $stable(vld_r), "pipeline moved during a stall")
  // An item in the last interior stage lands in the output register on the next move.
  `SWB_ASSERT(a_last_moves, adv && vld_r[NST-2] |=> out_bus.valid, "result lost at output")
  // Reset empties the pipeline.
  `SWB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> vld_r == '0, "valid bits survive reset")

endmodule

// ===== rtl/swb_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC: one binary angle in, Q1.14 sine and cosine out.
// Depends on swb_pkg. The pipeline advances only while en is high.
module swb_cordic import swb_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [15:0]              ang,
  output logic signed [TRIG_W-1:0] sin_o,
  output logic signed [TRIG_W-1:0] cos_o
);

  localparam int XW = 27;
  localparam int ZW = 34;
  localparam int SH = CORDIC_FRAC - TRIG_FRAC;
  localparam logic signed [ZW-1:0] QTURN = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] HTURN = ZW'(64'sd2147483648);

  logic signed [XW-1:0] x_r [STEPS+1];
  logic signed [XW-1:0] y_r [STEPS+1];
  logic signed [ZW-1:0] z_r [STEPS+1];
  logic                 flip_r [STEPS+1];

  logic signed [ZW-1:0] z0;
  logic signed [ZW-1:0] z0_nxt;
  logic                 flip_nxt;

  // Fold the angle into the right half plane and remember the half turn.
  always_comb begin
    z0 = ZW'($signed({ang, 16'd0}));
    z0_nxt   = z0;
    flip_nxt = 1'b0;
    if (z0 > QTURN) begin
      z0_nxt   = z0 - HTURN;
      flip_nxt = 1'b1;
    end else if (z0 < -QTURN) begin
      z0_nxt   = z0 + HTURN;
      flip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= XW'(CORDIC_GAIN);
      y_r[0]    <= '0;
      z_r[0]    <= z0_nxt;
      flip_r[0] <= flip_nxt;
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = ZW'(atan_turn(i));
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN;
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  logic signed [TRIG_W-1:0] cos_nxt;
  logic signed [TRIG_W-1:0] sin_nxt;
  logic signed [TRIG_W-1:0] cos_r;
  logic signed [TRIG_W-1:0] sin_r;

  // Drop to Q1.14 and undo the half-turn fold.
  always_comb begin
    cos_nxt = TRIG_W'(x_r[STEPS] >>> SH);
    sin_nxt = TRIG_W'(y_r[STEPS] >>> SH);
    if (flip_r[STEPS]) begin
      cos_nxt = -cos_nxt;
      sin_nxt = -sin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule
